// ===== rtl/sfeg_pkg.sv =====
package sfeg_pkg;

    // Framing
    localparam int FRAME_SAMPLES = 400;
    localparam int FRAME_STEP    = 160;
    localparam int MAX_FRAMES    = 256;

    // Frames judged per utterance, never more than the mask can hold
    localparam int JUDGE_CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

    // Most frames one sample can fall into
    localparam int NSPAN = (FRAME_SAMPLES + FRAME_STEP - 1) / FRAME_STEP;
    localparam int K_W   = $clog2(NSPAN + 1);

    // Sample counter, saturating
    localparam int             CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Frame index of the newest frame and phase within one step
    localparam int FHI_W = $clog2((2 ** CNT_W - 1) / FRAME_STEP + 1);
    localparam int POS_W = $clog2(FRAME_STEP);
    localparam int COV_W = $clog2(FRAME_SAMPLES + NSPAN * FRAME_STEP + 1);

    // Energy memory
    localparam int               ADDR_W = $clog2(MAX_FRAMES);
    localparam int               E_W    = 40;
    localparam logic [E_W-1:0]   E_MAX  = '1;
    localparam int               THR_W  = E_W + 16;

    // Judging and mask
    localparam int JIDX_W = 8;
    localparam int NF_W   = 9;
    localparam int WORDS  = 4;
    localparam int MASK_W = 64;

    // Ports
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 80;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SAMPLES  = 3'd0,
        REG_QUIET_PEAK   = 3'd1,
        REG_RATIO_SQ     = 3'd2,
        REG_FLOOR_ENERGY = 3'd3,
        REG_MIN_KEPT     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_QUIET  = 2'd2,
        ST_LITTLE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ACC_RD,
        OP_PEAK_RD,
        OP_KEEP_RD,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        logic [15:0]    min_samples;
        logic [14:0]    quiet_peak;
        logic [15:0]    ratio_sq;
        logic [E_W-1:0] floor_energy;
        logic [8:0]     min_kept;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [K_W-1:0]    k;
        logic [JIDX_W-1:0] scan;
    } cmd_t;

    typedef struct packed {
        logic            last;
        logic            early;
        logic [NF_W-1:0] nf;
    } stat_t;

    typedef struct packed {
        logic                            load;
        logic [WORDS-1:0][MASK_W-1:0]    mask;
        logic [8:0]                      kept;
        status_t                         status;
        logic [1:0]                      last_word;
    } result_t;

endpackage

// ===== rtl/sfeg_datapath.sv =====
module sfeg_datapath
    import sfeg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    input  logic signed [15:0] sample,
    input  logic               last_sample,
    input  logic [NF_W-1:0]    frame_total,
    output stat_t              stat,
    output result_t            res
);

    // Frame energy memory, valid bits mark written entries
    logic [E_W-1:0]        mem [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [E_W-1:0]        rd_data_reg;
    logic                  rd_vld_reg;

    // Utterance state
    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [FHI_W-1:0]  fhi_reg;
    logic [15:0]       peak_mag_reg;
    logic [E_W-1:0]    peak_e_reg;
    logic [8:0]        kept_reg;
    logic [WORDS-1:0][MASK_W-1:0] mask_reg;

    // Current sample
    logic [15:0]       mag_reg;
    logic [31:0]       sq_reg;
    logic              last_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [POS_W-1:0]  cur_pos_reg;
    logic [FHI_W-1:0]  cur_fhi_reg;
    logic              skip_reg;

    // Read pipeline
    op_t               pend_op_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [JIDX_W-1:0] pend_bit_reg;
    logic [THR_W-1:0]  thr_reg;

    logic [15:0]       mag;
    logic [NF_W-1:0]   nf_clamped;
    logic [FHI_W-1:0]  f_full;
    logic              cov;
    logic [ADDR_W-1:0] rd_addr;
    op_t               pend_op_next;
    logic [E_W-1:0]    eff;
    logic [E_W:0]      sum;
    logic [E_W-1:0]    wdata;
    logic              we;
    logic              rel;
    logic              above_floor;
    logic              too_short;
    logic              too_quiet;

    // Sample magnitude and frame count clamp
    assign mag        = sample[15] ? 16'(-sample) : 16'(sample);
    assign nf_clamped = (frame_total > NF_W'(JUDGE_CAP)) ? NF_W'(JUDGE_CAP) : frame_total;

    // Frame cur_fhi-k holds this sample when the sample lies within its span
    assign f_full = cur_fhi_reg - FHI_W'(cmd.k);
    assign cov    = !skip_reg && (cur_fhi_reg >= FHI_W'(cmd.k))
                    && ((COV_W'(cur_pos_reg) + COV_W'(cmd.k) * COV_W'(FRAME_STEP))
                        < COV_W'(FRAME_SAMPLES))
                    && (32'(f_full) < MAX_FRAMES);

    // Read address select
    always_comb
    begin
        rd_addr      = '0;
        pend_op_next = OP_NONE;
        unique case (cmd.op)
            OP_ACC_RD:
            begin
                rd_addr      = ADDR_W'(f_full);
                pend_op_next = cov ? OP_ACC_RD : OP_NONE;
            end
            OP_PEAK_RD, OP_KEEP_RD:
            begin
                rd_addr      = ADDR_W'(cmd.scan);
                pend_op_next = cmd.op;
            end
            default:
            begin
                rd_addr      = '0;
                pend_op_next = OP_NONE;
            end
        endcase
    end

    // Entries never written read as zero
    assign eff   = rd_vld_reg ? rd_data_reg : '0;
    assign sum   = {1'b0, eff} + (E_W + 1)'(sq_reg);
    assign wdata = sum[E_W] ? E_MAX : sum[E_W-1:0];
    assign we    = (pend_op_reg == OP_ACC_RD);

    // Relative and floor tests
    assign rel         = {eff, 16'b0} > thr_reg;
    assign above_floor = eff > cfg.floor_energy;

    // Memory port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[pend_addr_reg] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        sq_reg        <= mag_reg * mag_reg;
        thr_reg       <= cfg.ratio_sq * peak_e_reg;
        pend_addr_reg <= rd_addr;
        pend_bit_reg  <= cmd.scan;
        rd_vld_reg    <= valid_reg[rd_addr];
        if (cmd.op == OP_ACCEPT)
        begin
            mag_reg     <= mag;
            nf_reg      <= nf_clamped;
            cur_pos_reg <= pos_reg;
            cur_fhi_reg <= fhi_reg;
            skip_reg    <= (count_reg == CNT_MAX);
        end
    end

    // Utterance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            fhi_reg      <= '0;
            peak_mag_reg <= '0;
            peak_e_reg   <= '0;
            kept_reg     <= '0;
            mask_reg     <= '0;
            last_reg     <= 1'b0;
            pend_op_reg  <= OP_NONE;
        end
        else
        begin
            pend_op_reg <= pend_op_next;
            if (cmd.op == OP_PUBLISH)
            begin
                valid_reg    <= '0;
                count_reg    <= '0;
                pos_reg      <= '0;
                fhi_reg      <= '0;
                peak_mag_reg <= '0;
                peak_e_reg   <= '0;
                kept_reg     <= '0;
                mask_reg     <= '0;
                last_reg     <= 1'b0;
            end
            else
            begin
                // New sample: peak, count, frame phase
                if (cmd.op == OP_ACCEPT)
                begin
                    last_reg <= last_sample;
                    if (mag > peak_mag_reg)
                    begin
                        peak_mag_reg <= mag;
                    end
                    if (count_reg != CNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (pos_reg == POS_W'(FRAME_STEP - 1))
                        begin
                            pos_reg <= '0;
                            fhi_reg <= fhi_reg + 1'b1;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                // Completion of the pending read
                if (we)
                begin
                    valid_reg[pend_addr_reg] <= 1'b1;
                end
                if ((pend_op_reg == OP_PEAK_RD) && (eff > peak_e_reg))
                begin
                    peak_e_reg <= eff;
                end
                if ((pend_op_reg == OP_KEEP_RD) && rel && above_floor)
                begin
                    mask_reg[pend_bit_reg[JIDX_W-1:6]][pend_bit_reg[5:0]] <= 1'b1;
                    kept_reg <= kept_reg + 1'b1;
                end
            end
        end
    end

    // Early verdicts
    assign too_short = count_reg < CNT_W'(cfg.min_samples);
    assign too_quiet = peak_mag_reg < 16'(cfg.quiet_peak);

    assign stat.last  = last_reg;
    assign stat.early = too_short || too_quiet;
    assign stat.nf    = nf_reg;

    // Result handed to the output stage
    always_comb
    begin
        res.load = (cmd.op == OP_PUBLISH);
        res.mask = mask_reg;
        res.kept = kept_reg;
        if (too_short)
        begin
            res.status = ST_SHORT;
        end
        else if (too_quiet)
        begin
            res.status = ST_QUIET;
        end
        else if (kept_reg < cfg.min_kept)
        begin
            res.status = ST_LITTLE;
        end
        else
        begin
            res.status = ST_OK;
        end
        if (too_short || too_quiet || (nf_reg == '0))
        begin
            res.last_word = '0;
        end
        else
        begin
            res.last_word = 2'((nf_reg - 1'b1) >> 6);
        end
    end

    // A memory update never overlaps the end-of-utterance clear
    a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_op_reg != OP_NONE) |-> (cmd.op != OP_PUBLISH))
        else $error("pending read completes during utterance clear");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= 9'(JUDGE_CAP))
        else $error("kept count beyond judged frames");

endmodule

// ===== rtl/sfeg_ctrl.sv =====
module sfeg_ctrl
    import sfeg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    input  logic  out_ready,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CHECK,
        S_PEAK,
        S_PDRAIN,
        S_KEEP,
        S_KDRAIN,
        S_PUBLISH
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [K_W-1:0]  step_reg;
    logic [K_W-1:0]  step_next;
    logic [NF_W-1:0] scan_reg;
    logic [NF_W-1:0] scan_next;
    logic            ready_reg;
    logic            last_scan;

    assign last_scan = (scan_reg + 1'b1) == stat.nf;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    state_next = S_ACC;
                    step_next  = '0;
                end
            end
            S_ACC:
            begin
                if (step_reg == K_W'(NSPAN))
                begin
                    state_next = stat.last ? S_CHECK : S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                scan_next  = '0;
                state_next = (stat.early || (stat.nf == '0)) ? S_PUBLISH : S_PEAK;
            end
            S_PEAK:
            begin
                if (last_scan)
                begin
                    state_next = S_PDRAIN;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_PDRAIN:
            begin
                state_next = S_KEEP;
            end
            S_KEEP:
            begin
                if (last_scan)
                begin
                    state_next = S_KDRAIN;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_KDRAIN:
            begin
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            scan_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            scan_reg  <= scan_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

    // Datapath commands
    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.k    = step_reg;
        cmd.scan = JIDX_W'(scan_reg);
        unique case (state_reg)
            S_IDLE:    cmd.op = (s_tvalid && ready_reg) ? OP_ACCEPT : OP_NONE;
            S_ACC:     cmd.op = (step_reg < K_W'(NSPAN)) ? OP_ACC_RD : OP_NONE;
            S_PEAK:    cmd.op = OP_PEAK_RD;
            S_KEEP:    cmd.op = OP_KEEP_RD;
            S_PUBLISH: cmd.op = out_ready ? OP_PUBLISH : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    // Samples are taken only while no utterance is being judged
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input ready outside idle");

endmodule

// ===== rtl/sfeg_outq.sv =====
module sfeg_outq
    import sfeg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  result_t             res,
    output logic                out_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic [WORDS-1:0][MASK_W-1:0] mask_reg;
    logic [8:0]                   kept_reg;
    status_t                      status_reg;
    logic [1:0]                   last_word_reg;
    logic [1:0]                   cur_reg;
    logic                         busy_reg;

    // Result payload
    always_ff @(posedge clk)
    begin
        if (res.load && !busy_reg)
        begin
            mask_reg      <= res.mask;
            kept_reg      <= res.kept;
            status_reg    <= res.status;
            last_word_reg <= res.last_word;
        end
    end

    // Word sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cur_reg  <= '0;
        end
        else if (!busy_reg)
        begin
            if (res.load)
            begin
                busy_reg <= 1'b1;
                cur_reg  <= '0;
            end
        end
        else if (m_tready)
        begin
            if (cur_reg == last_word_reg)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
    end

    assign out_ready = !busy_reg;
    assign m_tvalid  = busy_reg;
    assign m_tlast   = (cur_reg == last_word_reg);
    assign m_tdata   = {3'b0, status_reg, kept_reg, cur_reg, mask_reg[cur_reg]};

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> !busy_reg)
        else $error("result loaded while words still pending");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("run of words ended before final word");

endmodule

// ===== rtl/speech_frame_energy_gate_top.sv =====
// Channel  Dir  Width  Contents (low bit up)
// s_*      in   32     sample[15:0], frame_total[24:16]; tlast = last_sample
// m_*      out  80     mask_word[63:0], word_index[65:64], kept_count[74:66],
//                      status[76:75]; tlast = end_of_run
// cfg_*    in   40     cfg_index selects register, cfg_data holds value
//
// Each sample is accepted, then each overlapping frame gets a read-modify-write
// through the energy memory port; the next sample is taken only after that.
// After the last sample come a check step, a peak scan, a keep scan and a publish
// step; the result words then leave one per cycle while m_tready is high.
// Reset and each utterance end clear the frame valid bits at once: no clearing pass.
// Samples of the next utterance are taken while words drain; m_tready low holds
// the word, and a final sample waits to publish until the previous run has left.
module speech_frame_energy_gate_top
    import sfeg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // sample[15:0], frame_total[24:16]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // mask_word, word_index, kept_count, status
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    stat_t   stat;
    result_t res;
    logic    out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_samples  <= 16'd4800;
            cfg_reg.quiet_peak   <= 15'd164;
            cfg_reg.ratio_sq     <= 16'd2621;
            cfg_reg.floor_energy <= 40'd42949673;
            cfg_reg.min_kept     <= 9'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_MIN_SAMPLES:  cfg_reg.min_samples  <= cfg_data[15:0];
                REG_QUIET_PEAK:   cfg_reg.quiet_peak   <= cfg_data[14:0];
                REG_RATIO_SQ:     cfg_reg.ratio_sq     <= cfg_data[15:0];
                REG_FLOOR_ENERGY: cfg_reg.floor_energy <= cfg_data[E_W-1:0];
                REG_MIN_KEPT:     cfg_reg.min_kept     <= cfg_data[8:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    sfeg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .stat      (stat),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sfeg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .sample      ($signed(s_tdata[15:0])),
        .last_sample (s_tlast),
        .frame_total (s_tdata[24:16]),
        .stat        (stat),
        .res         (res)
    );

    sfeg_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
